>>> rtl/core/vt_pkg.sv
// shared types and constants for the 4x4 vertex transform
// no dependencies; used by vt_dot_row, vertex_transform_4x4, vt_checker and the testbench
`default_nettype none

package vt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int NUM_COMP  = 4;
    localparam int PROD_W    = 2 * DATA_W;
    // four products summed without overflow
    localparam int SUM_W     = PROD_W + 2;

    localparam int NUM_REGS  = 8;
    localparam int CFG_W     = 64;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int ADDR_W    = IDX_W + 3;

    localparam int TDATA_W   = NUM_COMP * DATA_W;

    localparam logic [CFG_W-1:0] COEF_ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] COEF_ONE_HI = COEF_ONE_LO << DATA_W;

    // identity matrix after reset
    localparam logic [CFG_W-1:0] COEF_RESET [NUM_REGS] = '{
        COEF_ONE_LO, '0,
        COEF_ONE_HI, '0,
        '0, COEF_ONE_LO,
        '0, COEF_ONE_HI
    };

    typedef logic [NUM_COMP-1:0][DATA_W-1:0] vt_vec_t;

    typedef struct packed {
        logic prod_en;
        logic out_en;
    } vt_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/vt_dot_row.sv
// one matrix row: four products registered, then sum, floor shift and saturate
// depends on vt_pkg
`default_nettype none

module vt_dot_row
(
    input  wire logic                      clk,
    input  wire vt_pkg::vt_ctrl_t          ctrl,
    input  wire vt_pkg::vt_vec_t           coef,
    input  wire vt_pkg::vt_vec_t           vec,
    output logic [vt_pkg::DATA_W-1:0]      result
);

    logic signed [vt_pkg::PROD_W-1:0] prod_reg  [vt_pkg::NUM_COMP];
    logic signed [vt_pkg::PROD_W-1:0] prod_next [vt_pkg::NUM_COMP];
    logic signed [vt_pkg::SUM_W-1:0]  sum;
    logic signed [vt_pkg::SUM_W-1:0]  sum_sh;
    logic [vt_pkg::DATA_W-1:0]        result_reg;
    logic [vt_pkg::DATA_W-1:0]        result_next;

    always_comb
    begin
        for (int c = 0; c < vt_pkg::NUM_COMP; c++)
        begin
            prod_next[c] = vt_pkg::PROD_W'($signed(coef[c]) * $signed(vec[c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            for (int c = 0; c < vt_pkg::NUM_COMP; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    always_comb
    begin
        sum = vt_pkg::SUM_W'(prod_reg[0]) + vt_pkg::SUM_W'(prod_reg[1])
            + vt_pkg::SUM_W'(prod_reg[2]) + vt_pkg::SUM_W'(prod_reg[3]);
        // arithmetic shift floors toward minus infinity
        sum_sh = sum >>> vt_pkg::FRAC_BITS;
        if (sum_sh[vt_pkg::SUM_W-1:vt_pkg::DATA_W-1]
            != {(vt_pkg::SUM_W-vt_pkg::DATA_W+1){sum_sh[vt_pkg::DATA_W-1]}})
        begin
            result_next = sum_sh[vt_pkg::SUM_W-1]
                        ? {1'b1, {(vt_pkg::DATA_W-1){1'b0}}}
                        : {1'b0, {(vt_pkg::DATA_W-1){1'b1}}};
        end
        else
        begin
            result_next = sum_sh[vt_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/vertex_transform_4x4.sv
// top level of the 4x4 vertex transform: apb coefficient registers,
// three-stage stream pipeline; depends on vt_pkg and vt_dot_row
//
// usage:
//   s_axis carries one vertex per beat: tdata holds x, y, z, w (32-bit
//   signed fixed point, x in the lowest bits), tlast marks the end of a batch.
//   m_axis returns one transformed vertex per input beat in the same order,
//   tdata holds rows 0..3 of the product, tlast is the copy of the input flag.
//   the apb port holds the matrix as eight 64-bit registers at 8-byte steps,
//   two coefficients per register (even column in the low half).
//   an input beat reaches its output beat through the input register, the
//   product register (sixteen 32x32 multipliers) and the result register
//   (row sums, floor shift, saturation).
//   throughput is one vertex per cycle while m_axis_tready is high.
//   when the receiver stalls, the held result stays on m_axis and the
//   empty stages behind it still take beats; s_axis_tready drops only once
//   all three stages are full.
//   reset empties the pipeline and loads the identity matrix. the user must
//   rewrite coefficients only while no vertex is in flight; it is not enforced.
`default_nettype none

module vertex_transform_4x4
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vt_pkg::CFG_W-1:0]    pwdata,
    output logic      [vt_pkg::CFG_W-1:0]    prdata,
    output logic                             pready,

    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [vt_pkg::TDATA_W-1:0]  s_axis_tdata,   // vec_x, vec_y, vec_z, vec_w
    input  wire logic                        s_axis_tlast,

    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [vt_pkg::TDATA_W-1:0]  m_axis_tdata,   // out_x, out_y, out_z, out_w
    output logic                             m_axis_tlast
);

    logic [vt_pkg::CFG_W-1:0] coef_reg [vt_pkg::NUM_REGS];
    logic [vt_pkg::IDX_W-1:0] reg_idx;

    logic            in_valid_reg, in_valid_next;
    logic            prod_valid_reg, prod_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            in_last_reg, prod_last_reg, out_last_reg;
    vt_pkg::vt_vec_t vec_reg;

    logic             in_free, prod_free, out_free;
    vt_pkg::vt_ctrl_t ctrl;

    // configuration
    assign reg_idx = paddr[vt_pkg::ADDR_W-1:3];
    assign pready  = 1'b1;
    assign prdata  = coef_reg[reg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= vt_pkg::COEF_RESET[i];
            end
        end
        else if (psel && penable && pwrite)
        begin
            coef_reg[reg_idx] <= pwdata;
        end
    end

    // stage flow: a stage loads whenever it is empty or drains downstream
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign prod_free = !prod_valid_reg || out_free;
    assign in_free   = !in_valid_reg || prod_free;

    assign in_valid_next   = in_free   ? s_axis_tvalid  : in_valid_reg;
    assign prod_valid_next = prod_free ? in_valid_reg   : prod_valid_reg;
    assign out_valid_next  = out_free  ? prod_valid_reg : out_valid_reg;

    assign ctrl.prod_en = prod_free;
    assign ctrl.out_en  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free)
        begin
            vec_reg     <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (prod_free)
        begin
            prod_last_reg <= in_last_reg;
        end
        if (out_free)
        begin
            out_last_reg <= prod_last_reg;
        end
    end

    genvar r;
    generate
        for (r = 0; r < vt_pkg::NUM_COMP; r++)
        begin : g_row
            vt_pkg::vt_vec_t row_coef;

            assign row_coef[0] = coef_reg[2*r][vt_pkg::DATA_W-1:0];
            assign row_coef[1] = coef_reg[2*r][vt_pkg::CFG_W-1:vt_pkg::DATA_W];
            assign row_coef[2] = coef_reg[2*r+1][vt_pkg::DATA_W-1:0];
            assign row_coef[3] = coef_reg[2*r+1][vt_pkg::CFG_W-1:vt_pkg::DATA_W];

            vt_dot_row u_row
            (
                .clk    (clk),
                .ctrl   (ctrl),
                .coef   (row_coef),
                .vec    (vec_reg),
                .result (m_axis_tdata[r*vt_pkg::DATA_W +: vt_pkg::DATA_W])
            );
        end
    endgenerate

    assign s_axis_tready = in_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/vt_checker.sv
// port-level checks for vertex_transform_4x4, attached by bind
// depends on vt_pkg
`default_nettype none

module vt_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [vt_pkg::TDATA_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tlast
);

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // with the result stage empty the pipeline must take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // input back-pressure only comes from a stalled receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

endmodule

bind vertex_transform_4x4 vt_checker u_vt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/sv/vertex_transform_4x4_tb.sv
// self-checking testbench for vertex_transform_4x4: apb matrix loads,
// stream vertices in, transformed vertices checked against a local predictor
// depends on vt_pkg and the vertex_transform_4x4 rtl
`timescale 1ns / 100ps

module vertex_transform_4x4_tb;

    localparam int LATENCY         = 3;
    localparam int SETTLE_CYCLES   = LATENCY + 4;
    localparam int REG_STRIDE      = 8;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_GAP         = 20;
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum logic [2:0]
    {
        MAT_IDENTITY,
        MAT_MAX,
        MAT_MIN,
        MAT_FINE,
        MAT_RANDOM
    } matrix_kind_t;

    typedef enum logic [2:0]
    {
        FLOW_FREE,
        FLOW_TX_IDLE,
        FLOW_RX_STALL,
        FLOW_BOTH,
        FLOW_PRESSURE
    } flow_mode_t;

    typedef struct packed {
        logic [vt_pkg::DATA_W-1:0] x;
        logic [vt_pkg::DATA_W-1:0] y;
        logic [vt_pkg::DATA_W-1:0] z;
        logic [vt_pkg::DATA_W-1:0] w;
        logic                      last;
    } vertex_t;

    typedef struct packed {
        matrix_kind_t              mat;
        logic [vt_pkg::DATA_W-1:0] x;
        logic [vt_pkg::DATA_W-1:0] y;
        logic [vt_pkg::DATA_W-1:0] z;
        logic [vt_pkg::DATA_W-1:0] w;
        logic                      last;
        logic                      typed;
        logic [vt_pkg::DATA_W-1:0] ex;
        logic [vt_pkg::DATA_W-1:0] ey;
        logic [vt_pkg::DATA_W-1:0] ez;
        logic [vt_pkg::DATA_W-1:0] ew;
    } dir_row_t;

    localparam int NUM_DIRECTED = 16;

    // expected values typed in where they follow directly from the matrix
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{MAT_IDENTITY, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0,
          1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{MAT_IDENTITY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{MAT_IDENTITY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
          1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{MAT_IDENTITY, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
          1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF},
        '{MAT_IDENTITY, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0,
          1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0},
        '{MAT_IDENTITY, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
          1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA},
        // largest coefficients: positive and negative saturation
        '{MAT_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{MAT_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
          1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{MAT_MAX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
          1'b0, '0, '0, '0, '0},
        '{MAT_MAX, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
          1'b0, '0, '0, '0, '0},
        // most negative coefficients
        '{MAT_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
          1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{MAT_MIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
          1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{MAT_MIN, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0,
          1'b0, '0, '0, '0, '0},
        // one lsb on the diagonal: shift must floor negative values
        '{MAT_FINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{MAT_FINE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0001, 1'b0,
          1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
        '{MAT_FINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1,
          1'b1, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [vt_pkg::ADDR_W-1:0]    paddr;
    logic [vt_pkg::CFG_W-1:0]     pwdata;
    logic [vt_pkg::CFG_W-1:0]     prdata;
    logic                         pready;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [vt_pkg::TDATA_W-1:0]   s_axis_tdata;   // vec_x, vec_y, vec_z, vec_w
    logic                         s_axis_tlast;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [vt_pkg::TDATA_W-1:0]   m_axis_tdata;   // out_x, out_y, out_z, out_w
    logic                         m_axis_tlast;

    logic [vt_pkg::CFG_W-1:0] coef_shadow [vt_pkg::NUM_REGS];
    vertex_t          pending_vertices [$];
    vertex_t          head;
    vertex_t          got;
    int               err_count;
    int               cycle_count;
    int               tx_idle_pct;
    int               rx_stall_pct;
    int               hold_request;
    int               hold_left;

    vertex_transform_4x4 uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // row sums of coefficient times component, floored and saturated
    function automatic vertex_t transform(input vertex_t v);
        logic signed [vt_pkg::DATA_W-1:0] comp [vt_pkg::NUM_COMP];
        logic signed [vt_pkg::DATA_W-1:0] coef;
        logic signed [vt_pkg::SUM_W-1:0]  wide_c;
        logic signed [vt_pkg::SUM_W-1:0]  wide_v;
        logic signed [vt_pkg::SUM_W-1:0]  acc;
        logic signed [vt_pkg::SUM_W-1:0]  shifted;
        logic [vt_pkg::DATA_W-1:0]        row_out [vt_pkg::NUM_COMP];
        int row;
        int col;
        comp[0] = v.x;
        comp[1] = v.y;
        comp[2] = v.z;
        comp[3] = v.w;
        for (row = 0; row < vt_pkg::NUM_COMP; row++)
        begin
            acc = '0;
            for (col = 0; col < vt_pkg::NUM_COMP; col++)
            begin
                coef   = coef_shadow[row * 2 + col / 2]
                                    [(col % 2) * vt_pkg::DATA_W +: vt_pkg::DATA_W];
                wide_c = coef;
                wide_v = comp[col];
                acc    = acc + wide_c * wide_v;
            end
            shifted = acc >>> vt_pkg::FRAC_BITS;
            if (&shifted[vt_pkg::SUM_W-1:vt_pkg::DATA_W-1]
                || ~|shifted[vt_pkg::SUM_W-1:vt_pkg::DATA_W-1])
                row_out[row] = shifted[vt_pkg::DATA_W-1:0];
            else if (shifted[vt_pkg::SUM_W-1])
                row_out[row] = {1'b1, {(vt_pkg::DATA_W-1){1'b0}}};
            else
                row_out[row] = {1'b0, {(vt_pkg::DATA_W-1){1'b1}}};
        end
        transform.x    = row_out[0];
        transform.y    = row_out[1];
        transform.z    = row_out[2];
        transform.w    = row_out[3];
        transform.last = v.last;
    endfunction

    // extremes, values of a few integer bits, or anything
    function automatic logic [vt_pkg::DATA_W-1:0] rand_word(input int small_bits);
        logic [vt_pkg::DATA_W-1:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: rand_word = {1'b0, {(vt_pkg::DATA_W-1){1'b1}}};
            1: rand_word = {1'b1, {(vt_pkg::DATA_W-1){1'b0}}};
            2: rand_word = '0;
            3, 4: rand_word = $signed(r << (vt_pkg::DATA_W - small_bits))
                              >>> (vt_pkg::DATA_W - small_bits);
            default: rand_word = r;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        rand_vertex.x    = rand_word(22);
        rand_vertex.y    = rand_word(22);
        rand_vertex.z    = rand_word(22);
        rand_vertex.w    = rand_word(22);
        rand_vertex.last = ($urandom_range(7) == 0);
    endfunction

    function automatic logic [vt_pkg::CFG_W-1:0] coef_word(input matrix_kind_t kind,
                                                           input int idx);
        case (kind)
            MAT_IDENTITY: coef_word = vt_pkg::COEF_RESET[idx];
            MAT_MAX:      coef_word = {2{1'b0, {(vt_pkg::DATA_W-1){1'b1}}}};
            MAT_MIN:      coef_word = {2{1'b1, {(vt_pkg::DATA_W-1){1'b0}}}};
            MAT_FINE:     coef_word = vt_pkg::COEF_RESET[idx] >> vt_pkg::FRAC_BITS;
            default:      coef_word = {rand_word(18), rand_word(18)};
        endcase
    endfunction

    task automatic write_coef(input int idx, input logic [vt_pkg::CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= vt_pkg::ADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        coef_shadow[idx] = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_coef(input int idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= vt_pkg::ADDR_W'(idx * REG_STRIDE);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== coef_shadow[idx])
        begin
            $error("prdata reg %0d: expected %h, got %h", idx, coef_shadow[idx], prdata);
            err_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_matrix(input matrix_kind_t kind);
        int i;
        for (i = 0; i < vt_pkg::NUM_REGS; i++)
            write_coef(i, coef_word(kind, i));
        for (i = 0; i < vt_pkg::NUM_REGS; i++)
            read_coef(i);
    endtask

    task automatic send_vertex(input vertex_t v, input logic typed, input vertex_t want);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v.w, v.z, v.y, v.x};
        s_axis_tlast  <= v.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_vertices.push_back(typed ? want : transform(v));
    endtask

    // drop valid and let the pipeline empty before touching registers
    task automatic drain_stream();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [vt_pkg::DATA_W-1:0] want,
                               input logic [vt_pkg::DATA_W-1:0] actual);
        if (actual !== want)
        begin
            $error("%s: expected %h, got %h", name, want, actual);
            err_count++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall_pct == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x    = m_axis_tdata[0*vt_pkg::DATA_W +: vt_pkg::DATA_W];
            got.y    = m_axis_tdata[1*vt_pkg::DATA_W +: vt_pkg::DATA_W];
            got.z    = m_axis_tdata[2*vt_pkg::DATA_W +: vt_pkg::DATA_W];
            got.w    = m_axis_tdata[3*vt_pkg::DATA_W +: vt_pkg::DATA_W];
            got.last = m_axis_tlast;
            if (pending_vertices.size() == 0)
            begin
                $error("output beat with nothing expected: %h last %b", m_axis_tdata,
                       m_axis_tlast);
                err_count++;
            end
            else
            begin
                head = pending_vertices.pop_front();
                check_field("out_x", head.x, got.x);
                check_field("out_y", head.y, got.y);
                check_field("out_z", head.z, got.z);
                check_field("out_w", head.w, got.w);
                check_field("out_last", vt_pkg::DATA_W'(head.last),
                            vt_pkg::DATA_W'(got.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("vertex_transform_4x4_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        matrix_kind_t cur_mat;
        flow_mode_t   mode;
        vertex_t      v;
        vertex_t      want;
        int           i;
        int           m;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_request  = 0;
        for (i = 0; i < vt_pkg::NUM_REGS; i++)
            coef_shadow[i] = vt_pkg::COEF_RESET[i];

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < vt_pkg::NUM_REGS; i++)
            read_coef(i);

        // directed rows, identity matrix straight out of reset first
        cur_mat = MAT_IDENTITY;
        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].mat != cur_mat)
            begin
                drain_stream();
                cur_mat = DIRECTED[i].mat;
                load_matrix(cur_mat);
            end
            v.x       = DIRECTED[i].x;
            v.y       = DIRECTED[i].y;
            v.z       = DIRECTED[i].z;
            v.w       = DIRECTED[i].w;
            v.last    = DIRECTED[i].last;
            want.x    = DIRECTED[i].ex;
            want.y    = DIRECTED[i].ey;
            want.z    = DIRECTED[i].ez;
            want.w    = DIRECTED[i].ew;
            want.last = DIRECTED[i].last;
            send_vertex(v, DIRECTED[i].typed, want);
        end
        drain_stream();

        // random phases, a fresh matrix and flow pattern each
        for (m = FLOW_FREE; m <= FLOW_PRESSURE; m++)
        begin
            mode = flow_mode_t'(m);
            case (mode)
                FLOW_TX_IDLE:
                begin
                    tx_idle_pct  = 62;
                    rx_stall_pct = 0;
                end
                FLOW_RX_STALL:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 62;
                end
                FLOW_BOTH:
                begin
                    tx_idle_pct  = 25;
                    rx_stall_pct = 25;
                end
                default:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            load_matrix(MAT_RANDOM);
            if (mode == FLOW_PRESSURE)
            begin
                @(posedge clk);
                hold_request = HOLD_CYCLES;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_vertex(rand_vertex(), 1'b0, '0);
            drain_stream();
        end

        if (err_count == 0)
            $display("vertex_transform_4x4_tb: PASS");
        else
            $display("vertex_transform_4x4_tb: FAIL");
        $finish;
    end

endmodule

>>> vertex_transform_4x4.f
rtl/core/vt_pkg.sv
rtl/core/vt_dot_row.sv
rtl/core/vertex_transform_4x4.sv
rtl/core/vt_checker.sv
tb/sv/vertex_transform_4x4_tb.sv
